>>> sv/version_witness_table_unit_macros.svh
// Assertion macros used by the checker file of the version witness table.
`ifndef VERSION_WITNESS_TABLE_UNIT_MACROS_SVH
`define VERSION_WITNESS_TABLE_UNIT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define VWT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define VWT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/vwt_pkg.sv
// Shared types, codes and sizes of the version witness table.
package vwt_pkg;

  // Default number of table entries.
  localparam int TableDepth = 64;

  // Command codes.
  localparam logic CMD_COMMIT = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ROLLBACK     = 3'd1;
  localparam logic [2:0] ST_UNREGISTERED = 3'd2;
  localparam logic [2:0] ST_UNCOMMITTED  = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  // One decoded request.
  typedef struct packed {
    logic        cmd;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [63:0] claim;
  } req_t;

  // One table entry.
  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [63:0] version;
  } entry_t;

endpackage

>>> sv/vwt_front.sv
// Input stage: takes a request word and holds it until the queue takes it.
module vwt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [63:0]       vault_id_high,
  input  logic [63:0]       vault_id_low,
  input  logic [63:0]       claimed_version,
  output logic              fr_valid,
  output vwt_pkg::req_t     fr_data,
  input  logic              q_full
);

  logic take;
  logic drain;

  assign drain = fr_valid && !q_full;
  assign full  = fr_valid && q_full;
  assign take  = push && !full;

  // Holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (take) begin
      fr_valid <= 1'b1;
    end else if (drain) begin
      fr_valid <= 1'b0;
    end
  end

  // Request word, decoded into the shared layout
  always_ff @(posedge clk) begin
    if (take) begin
      fr_data.cmd     <= (command == vwt_pkg::CMD_CHECK) ? vwt_pkg::CMD_CHECK
                                                         : vwt_pkg::CMD_COMMIT;
      fr_data.id_high <= vault_id_high;
      fr_data.id_low  <= vault_id_low;
      fr_data.claim   <= claimed_version;
    end
  end

endmodule

>>> sv/vwt_queue.sv
// Two-entry request queue between the input stage and the table engine.
module vwt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  input  vwt_pkg::req_t wr_data,
  output logic          q_full,
  output logic          q_valid,
  output vwt_pkg::req_t q_data,
  input  logic          q_pop
);

  vwt_pkg::req_t slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    cnt;
  logic          wr_en;
  logic          rd_en;

  assign q_full  = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_data  = slots[rptr];
  assign wr_en   = wr_valid && !q_full;
  assign rd_en   = q_pop && q_valid;

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr_en) wptr <= ~wptr;
      if (rd_en) rptr <= ~rptr;
      if (wr_en && !rd_en) begin
        cnt <= cnt + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) slots[wptr] <= wr_data;
  end

endmodule

>>> sv/vwt_engine.sv
// Table engine: scans the entries, decides the status and updates the table.
module vwt_engine #(
  parameter int TABLE_DEPTH = vwt_pkg::TableDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  vwt_pkg::req_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [2:0]    status,
  output logic [63:0]   reported_version
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]      state;
  vwt_pkg::req_t   req;
  logic [CW-1:0]   count;
  logic [CW-1:0]   issue_idx;
  logic            pend;
  logic [AW-1:0]   pend_idx;
  logic            hit;
  logic [AW-1:0]   hit_idx;
  logic [63:0]     trusted;
  logic            out_valid;

  vwt_pkg::entry_t mem [TABLE_DEPTH];
  vwt_pkg::entry_t mem_q;

  logic            match;
  logic            rd_en;
  logic            fin_go;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            alloc;
  logic            tbl_full;
  logic            lt;
  logic            gt;
  logic [2:0]      status_next;
  logic [63:0]     rep_next;

  assign empty = !out_valid;
  assign q_pop = (state == S_IDLE) && q_valid;

  // Scan compare on the registered read data
  assign match = pend && (mem_q.id_high == req.id_high) && (mem_q.id_low == req.id_low);
  assign rd_en = (state == S_SCAN) && !match && (issue_idx != count);

  // Decision once the scan is over
  assign tbl_full = (count == CW'(TABLE_DEPTH));
  assign lt       = req.claim < trusted;
  assign gt       = req.claim > trusted;
  assign fin_go   = (state == S_FIN) && (!out_valid || pop);

  always_comb begin
    status_next = vwt_pkg::ST_OK;
    rep_next    = trusted;
    wr_en       = 1'b0;
    alloc       = 1'b0;
    wr_addr     = hit_idx;
    if (req.cmd == vwt_pkg::CMD_COMMIT) begin
      if (lt) begin
        status_next = vwt_pkg::ST_ROLLBACK;
      end else if (hit) begin
        rep_next = req.claim;
        wr_en    = fin_go;
      end else if (!tbl_full) begin
        rep_next = req.claim;
        wr_en    = fin_go;
        alloc    = fin_go;
        wr_addr  = count[AW-1:0];
      end else begin
        status_next = vwt_pkg::ST_FULL;
        rep_next    = 64'd0;
      end
    end else begin
      if (trusted == 64'd0) begin
        status_next = vwt_pkg::ST_UNREGISTERED;
        rep_next    = 64'd0;
      end else if (lt) begin
        status_next = vwt_pkg::ST_ROLLBACK;
      end else if (gt) begin
        status_next = vwt_pkg::ST_UNCOMMITTED;
      end
    end
  end

  // Entry memory: one read port with registered data, one write port
  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[issue_idx[AW-1:0]];
    if (wr_en) mem[wr_addr] <= '{id_high: req.id_high, id_low: req.id_low, version: req.claim};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Result word: loaded when a decision issues, dropped when popped
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            req       <= q_data;
            issue_idx <= '0;
            hit       <= 1'b0;
            trusted   <= 64'd0;
            pend      <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit     <= 1'b1;
            hit_idx <= pend_idx;
            trusted <= mem_q.version;
            pend    <= 1'b0;
            state   <= S_FIN;
          end else if (!pend && (issue_idx == count)) begin
            state <= S_FIN;
          end else begin
            pend <= rd_en;
            if (rd_en) begin
              pend_idx  <= issue_idx[AW-1:0];
              issue_idx <= issue_idx + CW'(1);
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            status           <= status_next;
            reported_version <= rep_next;
            if (alloc) count <= count + CW'(1);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/version_witness_table_unit.sv
// Top level of the version witness table: input stage, request queue, table engine.
//
//  channel  | handshake   | ports
//  ---------+-------------+--------------------------------------------------
//  request  | push / full | command, vault_id_high, vault_id_low, claimed_version
//  result   | pop / empty | status, reported_version
//
// For a request the engine scans the n filled entries of the table:
// it reads one entry a cycle from the single read port of the entry
// memory and stops at the first match, so it reads at most TABLE_DEPTH entries.
// Reset clears the fill count; no clearing pass is needed.
// Up to three requests queue ahead of the engine while a result waits for pop.
module version_witness_table_unit #(
  parameter int TABLE_DEPTH = vwt_pkg::TableDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [63:0] vault_id_high,
  input  logic [63:0] vault_id_low,
  input  logic [63:0] claimed_version,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [63:0] reported_version
);

  logic          fr_valid;
  vwt_pkg::req_t fr_data;
  logic          q_full;
  logic          q_valid;
  vwt_pkg::req_t q_data;
  logic          q_pop;

  vwt_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .command         (command),
    .vault_id_high   (vault_id_high),
    .vault_id_low    (vault_id_low),
    .claimed_version (claimed_version),
    .fr_valid        (fr_valid),
    .fr_data         (fr_data),
    .q_full          (q_full)
  );

  vwt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_data  (fr_data),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  vwt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .status           (status),
    .reported_version (reported_version)
  );

endmodule

>>> sv/vwt_checker.sv
// Port-level checks of the version witness table and their bind.
`include "version_witness_table_unit_macros.svh"

module vwt_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status,
  input logic [63:0] reported_version
);

  logic        shows_full;
  logic        shows_unreg;
  logic        ver_zero;
  logic [66:0] word;

  assign shows_full  = !empty && (status == vwt_pkg::ST_FULL);
  assign shows_unreg = !empty && (status == vwt_pkg::ST_UNREGISTERED);
  assign ver_zero    = (reported_version == 64'd0);
  assign word        = {status, reported_version};

  `VWT_ASSERT_ALWAYS(a_rst_empty, rst |=> empty && !full, "not empty or full after reset")
  `VWT_ASSERT(a_status_code, !empty |-> status <= vwt_pkg::ST_FULL, "status code out of range")
  `VWT_ASSERT(a_full_zero, shows_full |-> ver_zero, "table full with nonzero version")
  `VWT_ASSERT(a_unreg_zero, shows_unreg |-> ver_zero, "unregistered with nonzero version")
  `VWT_ASSERT(a_hold, (!empty && !pop) |=> !empty && $stable(word), "waiting word changed")

endmodule

bind version_witness_table_unit vwt_port_checker u_vwt_checker (.*);
